// ----- sv/wpc_pkg.sv -----
`timescale 1ns / 1ps
package wpc_pkg;
	localparam int MAX_WINDOW_DEF  = 1024;
	localparam int MAX_LENGTH_DEF  = 65536;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int CFG_W           = 11;
	localparam int PARTS_W         = 10;
	localparam int START_W         = 16;
	localparam int MIN_WINDOW      = 3;
	localparam logic [CFG_W-1:0] WINDOW_LEN_RST = CFG_W'(3);
endpackage

// ----- sv/wpc_ifs.sv -----
`timescale 1ns / 1ps
interface wpc_in_if
	import wpc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface wpc_out_if
	import wpc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [PARTS_W-1:0] best_parts;
	logic [START_W-1:0] best_start;
	logic               valid_res;

	modport source (output valid, output best_parts, output best_start, output valid_res,
		input ready);
	modport sink (input valid, input best_parts, input best_start, input valid_res,
		output ready);
endinterface

// ----- sv/window_peak_count_max_unit.sv -----
`timescale 1ns / 1ps
// Sliding-window peak counter.
// The samples channel takes one word per cycle unless stalled, each an unsigned sample
// with a last mark that closes the sequence. A sample is a peak when it is strictly
// greater than both neighbors; every window of window_len samples counts the peaks
// strictly inside it, and the block keeps the largest count, leftmost window on ties.
// On the last word of a sequence the results channel delivers one word: best_parts
// (count plus one), best_start (1-based window start) and valid_res, which is zero with
// the other fields zero when the sequence was shorter than the window.
// Throughput is one sample per cycle unless a stalled result holds the channel.
// The peak prefix count memory is written and read in the cycle a sample is taken;
// the window count and best update follow from the s1 registers, which on a last
// sample also load the output register that offers the result word.
// window_len is written through cfg_wr_en and cfg_wr_data only while the block is
// idle, a user rule the block does not enforce. Reset clears the sequence state and
// sets window_len to 3; the memory needs no clearing. A stalled receiver leaves one
// result in the output register; samples flow until a second last sample needs it.
module window_peak_count_max_unit
	import wpc_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	wpc_in_if.sink           samples,
	wpc_out_if.source        results
);
	localparam int IW = $clog2(MAX_WINDOW);
	localparam int KW = $clog2(MAX_WINDOW + 1);
	localparam int PW = $clog2(MAX_LENGTH);

	logic [CFG_W-1:0]       window_len_q;
	logic [SAMPLE_BITS-1:0] older_q;
	logic [SAMPLE_BITS-1:0] newer_q;
	logic [PW-1:0]          position_q;
	logic [IW-1:0]          widx_q;
	logic [PARTS_W-1:0]     prefix_q;
	logic [PARTS_W-1:0]     mem [MAX_WINDOW];

	logic                   s1_valid_q;
	logic                   last_s1;
	logic                   upd_s1;
	logic [PARTS_W-1:0]     cur_s1;
	logic [PARTS_W-1:0]     rd_s1;
	logic [START_W-1:0]     start_s1;

	logic                   have_best_q;
	logic [PARTS_W-1:0]     best_cnt_q;
	logic [START_W-1:0]     best_idx_q;

	logic                   out_valid_q;
	logic [PARTS_W-1:0]     parts_q;
	logic [START_W-1:0]     start_q;
	logic                   res_valid_q;

	logic                   accept;
	logic                   s1_adv;
	logic                   advance;
	logic [KW-1:0]          klen;
	logic [PW-1:0]          p;
	logic                   peak;
	logic                   wr_en;
	logic                   win_done;
	logic [PARTS_W-1:0]     prefix_nxt;
	logic [IW:0]            rdiff;
	logic [IW-1:0]          ridx;
	logic [PARTS_W-1:0]     cnt;
	logic                   take;
	logic                   nb_have;
	logic [PARTS_W-1:0]     nb_cnt;
	logic [START_W-1:0]     nb_idx;

	always_comb begin
		if (window_len_q < CFG_W'(MIN_WINDOW)) begin
			klen = KW'(MIN_WINDOW);
		end else if (32'(window_len_q) > 32'(MAX_WINDOW)) begin
			klen = KW'(MAX_WINDOW);
		end else begin
			klen = KW'(window_len_q);
		end
	end

	assign s1_adv         = !last_s1 || !out_valid_q || results.ready;
	assign samples.ready  = !s1_valid_q || s1_adv;
	assign accept         = samples.valid && samples.ready;
	assign advance        = 32'(position_q) + 32'd1 < 32'(MAX_LENGTH);
	assign p              = position_q + PW'(1);
	assign peak           = (position_q >= PW'(2)) && (older_q < newer_q)
		&& (newer_q > samples.sample);
	assign wr_en          = accept && advance && (position_q >= PW'(1));
	assign win_done       = advance && (32'(p) >= 32'(klen));
	assign prefix_nxt     = prefix_q + PARTS_W'(peak);
	assign rdiff          = {1'b0, widx_q} - (IW + 1)'(klen - KW'(2));
	assign ridx           = rdiff[IW] ? IW'(rdiff + (IW + 1)'(MAX_WINDOW)) : rdiff[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
		end else if (cfg_wr_en) begin
			window_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[widx_q] <= prefix_nxt;
		end
		if (accept) begin
			rd_s1 <= mem[ridx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q    <= '0;
			newer_q    <= '0;
			position_q <= '0;
			widx_q     <= '0;
			prefix_q   <= '0;
		end else if (accept) begin
			if (samples.last) begin
				older_q    <= '0;
				newer_q    <= '0;
				position_q <= '0;
				widx_q     <= '0;
				prefix_q   <= '0;
			end else if (advance) begin
				older_q    <= newer_q;
				newer_q    <= samples.sample;
				position_q <= p;
				widx_q     <= (32'(widx_q) == MAX_WINDOW - 1) ? '0 : widx_q + IW'(1);
				if (position_q >= PW'(1)) begin
					prefix_q <= prefix_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= samples.last;
			upd_s1   <= win_done;
			cur_s1   <= prefix_nxt;
			start_s1 <= START_W'(32'(p) - 32'(klen) + 32'd1);
		end
	end

	assign cnt  = cur_s1 - rd_s1;
	assign take = upd_s1 && (!have_best_q || cnt > best_cnt_q);

	always_comb begin
		nb_have = have_best_q;
		nb_cnt  = best_cnt_q;
		nb_idx  = best_idx_q;
		if (take) begin
			nb_have = 1'b1;
			nb_cnt  = cnt;
			nb_idx  = start_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			best_cnt_q  <= '0;
			best_idx_q  <= '0;
		end else if (s1_valid_q && s1_adv) begin
			if (last_s1) begin
				have_best_q <= 1'b0;
				best_cnt_q  <= '0;
				best_idx_q  <= '0;
			end else begin
				have_best_q <= nb_have;
				best_cnt_q  <= nb_cnt;
				best_idx_q  <= nb_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv && last_s1) begin
			parts_q     <= nb_have ? nb_cnt + PARTS_W'(1) : '0;
			start_q     <= nb_have ? nb_idx : '0;
			res_valid_q <= nb_have;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.best_parts = parts_q;
	assign results.best_start = start_q;
	assign results.valid_res  = res_valid_q;

	a_short_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_valid_q |-> parts_q == '0 && start_q == '0)
		else $error("short-sequence result carries nonzero fields");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && win_done |-> ridx != widx_q)
		else $error("prefix memory read and write hit the same entry");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> s1_valid_q && last_s1 && out_valid_q)
		else $error("sample channel stalled without a pending result");

	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_adv && last_s1 |=> !have_best_q)
		else $error("best window not cleared after a sequence ended");
endmodule
